// File: rtl/bracket_depth_scanner_core_assert.svh
// Assertion macros for the bracket depth scanner.
// BDS_ASSERT_IMP checks cons in the same cycle as ante; BDS_ASSERT_NXT in the cycle after.
`ifndef BRACKET_DEPTH_SCANNER_CORE_ASSERT_SVH
`define BRACKET_DEPTH_SCANNER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bds assertion failed");
`define BDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bds assertion failed");
`else
`define BDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/bds_pkg.sv
package bds_pkg;

    // beat kinds carried on tuser
    localparam logic [1:0] OP_MID   = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_EAT,
        ACT_STOP
    } t_act;

    // result beat, lowest field last
    typedef struct packed {
        logic [4:0]  pad;
        logic        inside_comment;
        logic        quote_is_single;
        logic        inside_string;
        logic [15:0] nesting_depth;
    } t_result;

endpackage

// File: rtl/bracket_depth_scanner_core.sv
// Channel   Dir  Fields (tdata / tuser, lowest bit up)
// s_axis    in   tdata[15:0] code_unit; tuser[1:0] op
// m_axis    out  tdata[15:0] nesting_depth, [16] inside_string,
//                [17] quote_is_single, [18] inside_comment, [23:19] zero
//
// One character beat is taken every cycle while s_axis is open; its result (line
// end or empty line) goes to the result register, or to the skid when that one
// is full and not popped. The lexical state is updated combinationally by up to
// two chained settle passes (held character with lookahead, then the line-end
// character without) between the input port and the state and result registers.
// A two-entry output stage (result register plus skid) keeps s_axis open
// while one result waits; s_axis stalls only when both entries are full.
// Synchronous active-low reset clears the lexical state and both output entries.
`include "bracket_depth_scanner_core_assert.svh"

module bracket_depth_scanner_core
    import bds_pkg::*;
#(
    parameter int DEPTH_WIDTH = 16,
    parameter int CHAR_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [15:0] code_unit
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata   // depth, in string, single quote, in comment, pad
);

    typedef struct packed {
        logic [DEPTH_WIDTH-1:0] depth;
        logic                   str;
        logic                   qk;
        logic                   cmt;
    } t_lex;

    typedef struct packed {
        t_lex st;
        t_act act;
    } t_settle;

    localparam logic [CHAR_WIDTH-1:0] K_LBRACE = CHAR_WIDTH'(CH_LBRACE);
    localparam logic [CHAR_WIDTH-1:0] K_RBRACE = CHAR_WIDTH'(CH_RBRACE);
    localparam logic [CHAR_WIDTH-1:0] K_LBRACK = CHAR_WIDTH'(CH_LBRACK);
    localparam logic [CHAR_WIDTH-1:0] K_RBRACK = CHAR_WIDTH'(CH_RBRACK);
    localparam logic [CHAR_WIDTH-1:0] K_LPAREN = CHAR_WIDTH'(CH_LPAREN);
    localparam logic [CHAR_WIDTH-1:0] K_RPAREN = CHAR_WIDTH'(CH_RPAREN);
    localparam logic [CHAR_WIDTH-1:0] K_DQUOTE = CHAR_WIDTH'(CH_DQUOTE);
    localparam logic [CHAR_WIDTH-1:0] K_APOS   = CHAR_WIDTH'(CH_APOS);
    localparam logic [CHAR_WIDTH-1:0] K_SLASH  = CHAR_WIDTH'(CH_SLASH);
    localparam logic [CHAR_WIDTH-1:0] K_STAR   = CHAR_WIDTH'(CH_STAR);
    localparam logic [CHAR_WIDTH-1:0] K_BSLASH = CHAR_WIDTH'(CH_BSLASH);

    // Settle one character against the lexical state. nx is the lookahead,
    // pv the raw previous character on the line (for the escape check).
    function automatic t_settle settle(
        input t_lex                  s,
        input logic [CHAR_WIDTH-1:0] c,
        input logic                  has_nx,
        input logic [CHAR_WIDTH-1:0] nx,
        input logic                  has_pv,
        input logic [CHAR_WIDTH-1:0] pv
    );
        t_settle r;
        r.st  = s;
        r.act = ACT_NONE;
        if (!s.cmt && !s.str && (c == K_APOS || c == K_DQUOTE)) begin
            r.st.str = 1'b1;
            r.st.qk  = (c == K_APOS);
        end else if (!s.cmt && s.str && c == (s.qk ? K_APOS : K_DQUOTE)) begin
            if (!(has_pv && pv == K_BSLASH)) begin
                r.st.str = 1'b0;
            end
        end else if (s.str) begin
            // string body: nothing counts
        end else if (!s.cmt && has_nx && c == K_SLASH && nx == K_STAR) begin
            r.st.cmt = 1'b1;
            r.act    = ACT_EAT;
        end else if (s.cmt && has_nx && c == K_STAR && nx == K_SLASH) begin
            r.st.cmt = 1'b0;
            r.act    = ACT_EAT;
        end else if (s.cmt) begin
            // comment body: nothing counts
        end else if (has_nx && c == K_SLASH && nx == K_SLASH) begin
            r.act = ACT_STOP;
        end else if (c == K_LBRACE || c == K_LBRACK || c == K_LPAREN) begin
            if (s.depth != '1) begin
                r.st.depth = s.depth + 1'b1;
            end
        end else if (c == K_RBRACE || c == K_RBRACK || c == K_RPAREN) begin
            if (s.depth != '0) begin
                r.st.depth = s.depth - 1'b1;
            end
        end
        return r;
    endfunction

    // lexical and line-local state
    t_lex                  r_lex, n_lex;
    logic [CHAR_WIDTH-1:0] r_held, n_held;
    logic                  r_held_valid, n_held_valid;
    logic [CHAR_WIDTH-1:0] r_before, n_before;
    logic                  r_before_valid, n_before_valid;
    logic                  r_skip, n_skip;
    logic                  r_rest, n_rest;

    // output stage
    logic    r_out_valid, n_out_valid;
    t_result r_out_data, n_out_data;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid_data, n_skid_data;

    logic                  s_acc;
    logic                  pop;
    logic                  has_result;
    logic [CHAR_WIDTH-1:0] c_in;
    t_settle               set_a;
    t_settle               set_b;
    t_lex                  lex_a;
    t_lex                  lex_fin;
    logic                  eat_a;
    logic                  rest_a;
    logic [32:0]           depth_ext;
    t_result               res;

    assign o_s_axis_tready = !r_skid_valid;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = r_out_valid && i_m_axis_tready;
    assign c_in            = i_s_axis_tdata[CHAR_WIDTH-1:0];
    assign has_result      = (i_s_axis_tuser == OP_END) || (i_s_axis_tuser == OP_EMPTY);

    // first pass: settle the held character with the new one as lookahead
    assign set_a  = settle(r_lex, r_held, 1'b1, c_in, r_before_valid, r_before);
    assign eat_a  = !r_rest && r_held_valid && !r_skip && (set_a.act == ACT_EAT);
    assign rest_a = r_rest || (r_held_valid && !r_skip && (set_a.act == ACT_STOP));
    assign lex_a  = (!r_rest && r_held_valid && !r_skip) ? set_a.st : r_lex;

    // second pass at line end: settle the new character with no lookahead
    assign set_b = settle(lex_a, c_in, 1'b0, '0, r_held_valid, r_held);

    always_comb begin
        n_lex          = r_lex;
        n_held         = r_held;
        n_held_valid   = r_held_valid;
        n_before       = r_before;
        n_before_valid = r_before_valid;
        n_skip         = r_skip;
        n_rest         = r_rest;
        lex_fin        = r_lex;

        if (s_acc) begin
            case (i_s_axis_tuser)
                OP_MID: begin
                    n_lex = lex_a;
                    n_rest = rest_a;
                    if (!r_rest) begin
                        // shift the line window
                        n_before       = r_held;
                        n_before_valid = r_held_valid;
                        n_held         = c_in;
                        n_held_valid   = 1'b1;
                        n_skip         = eat_a;
                    end
                end
                OP_END: begin
                    lex_fin = (!rest_a && !(r_rest ? r_skip : eat_a)) ? set_b.st : lex_a;
                    n_lex   = lex_fin;
                end
                OP_EMPTY: begin
                    lex_fin = r_lex;
                end
                default: begin
                    // unused kind: drop the beat
                end
            endcase
            if (has_result) begin
                // clear line-local state after every report
                n_held         = '0;
                n_held_valid   = 1'b0;
                n_before       = '0;
                n_before_valid = 1'b0;
                n_skip         = 1'b0;
                n_rest         = 1'b0;
            end
        end
    end

    // report: clamp depth to the 16-bit field
    always_comb begin
        depth_ext           = 33'(lex_fin.depth);
        res.pad             = '0;
        res.inside_comment  = lex_fin.cmt;
        res.quote_is_single = lex_fin.str && lex_fin.qk;
        res.inside_string   = lex_fin.str;
        res.nesting_depth   = (depth_ext > 33'h0FFFF) ? 16'hFFFF : depth_ext[15:0];
    end

    // two-entry output: result register with skid behind it
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (s_acc && has_result) begin
            if (!r_out_valid || pop) begin
                n_out_valid = 1'b1;
                n_out_data  = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = res;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lex          <= '0;
            r_held         <= '0;
            r_held_valid   <= 1'b0;
            r_before       <= '0;
            r_before_valid <= 1'b0;
            r_skip         <= 1'b0;
            r_rest         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_skid_valid   <= 1'b0;
        end else begin
            r_lex          <= n_lex;
            r_held         <= n_held;
            r_held_valid   <= n_held_valid;
            r_before       <= n_before;
            r_before_valid <= n_before_valid;
            r_skip         <= n_skip;
            r_rest         <= n_rest;
            r_out_valid    <= n_out_valid;
            r_skid_valid   <= n_skid_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `BDS_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `BDS_ASSERT_IMP(a_quote_needs_string, i_clk, i_rst_n, r_out_valid,
        (!r_out_data.quote_is_single || r_out_data.inside_string))
    `BDS_ASSERT_NXT(a_line_cleared, i_clk, i_rst_n, (s_acc && has_result),
        (!r_held_valid && !r_skip && !r_rest && !r_before_valid))
    `BDS_ASSERT_NXT(a_no_result_holds, i_clk, i_rst_n, (s_acc && !has_result && !pop),
        ($stable(r_out_valid) && $stable(r_skid_valid)))

endmodule

// File: bench/bracket_depth_scanner_core_tb.sv
`timescale 1ns / 1ps

module bracket_depth_scanner_core_tb;
    import bds_pkg::*;

    // tuser value the block must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RANDOM_BEATS = 400;

    // Line-level lexical state tracker: follows every accepted beat and keeps
    // the line reports that the block still owes.
    class line_state_tracker;
        logic [15:0] depth;
        bit          string_open;
        bit          quote_single;
        bit          comment_open;
        logic [15:0] held_unit;
        logic [15:0] prev_unit;
        bit          held_valid;
        bit          prev_valid;
        bit          skip_next;
        bit          rest_ignored;
        t_result     reports_due[$];
        int unsigned mismatches;
        int unsigned reports_checked;
        logic [15:0] deepest;

        function new();
            depth           = '0;
            string_open     = 1'b0;
            quote_single    = 1'b0;
            comment_open    = 1'b0;
            held_unit       = '0;
            prev_unit       = '0;
            held_valid      = 1'b0;
            prev_valid      = 1'b0;
            skip_next       = 1'b0;
            rest_ignored    = 1'b0;
            mismatches      = 0;
            reports_checked = 0;
            deepest         = '0;
        endfunction

        // Resolve one character, with optional lookahead; the escape test
        // looks at the raw character before the held one.
        function t_act settle(logic [15:0] c, bit has_nx, logic [15:0] nx_unit);
            if (!comment_open) begin
                if (!string_open && (c == CH_APOS || c == CH_DQUOTE)) begin
                    string_open  = 1'b1;
                    quote_single = (c == CH_APOS);
                    return ACT_NONE;
                end
                if (string_open && c == (quote_single ? CH_APOS : CH_DQUOTE)) begin
                    if (!(prev_valid && prev_unit == CH_BSLASH))
                        string_open = 1'b0;
                    return ACT_NONE;
                end
            end
            if (string_open)
                return ACT_NONE;
            if (!comment_open && has_nx && c == CH_SLASH && nx_unit == CH_STAR) begin
                comment_open = 1'b1;
                return ACT_EAT;
            end
            if (comment_open && has_nx && c == CH_STAR && nx_unit == CH_SLASH) begin
                comment_open = 1'b0;
                return ACT_EAT;
            end
            if (comment_open)
                return ACT_NONE;
            if (has_nx && c == CH_SLASH && nx_unit == CH_SLASH)
                return ACT_STOP;
            if (c == CH_LBRACE || c == CH_LBRACK || c == CH_LPAREN) begin
                if (depth != 16'hFFFF)
                    depth++;
            end else if (c == CH_RBRACE || c == CH_RBRACK || c == CH_RPAREN) begin
                if (depth != '0)
                    depth--;
            end
            return ACT_NONE;
        endfunction

        // Queue the line report and drop all line-local state.
        function void push_report();
            t_result r;
            r.pad             = '0;
            r.nesting_depth   = depth;
            r.inside_string   = string_open;
            r.quote_is_single = string_open && quote_single;
            r.inside_comment  = comment_open;
            reports_due.push_back(r);
            if (depth > deepest)
                deepest = depth;
            held_unit    = '0;
            prev_unit    = '0;
            held_valid   = 1'b0;
            prev_valid   = 1'b0;
            skip_next    = 1'b0;
            rest_ignored = 1'b0;
        endfunction

        function void note_beat(logic [1:0] op, logic [15:0] unit);
            t_act act;
            bit   eat;
            if (op == OP_UNUSED)
                return;
            if (op == OP_EMPTY) begin
                push_report();
                return;
            end
            if (!rest_ignored) begin
                eat = 1'b0;
                if (held_valid && !skip_next) begin
                    act = settle(held_unit, 1'b1, unit);
                    if (act == ACT_EAT)
                        eat = 1'b1;
                    else if (act == ACT_STOP)
                        rest_ignored = 1'b1;
                end
                prev_unit  = held_unit;
                prev_valid = held_valid;
                held_unit  = unit;
                held_valid = 1'b1;
                skip_next  = eat;
            end
            if (op == OP_MID)
                return;
            // line end: settle the held character with no lookahead
            if (!rest_ignored && !skip_next)
                void'(settle(held_unit, 1'b0, '0));
            push_report();
        endfunction

        function void check_report(logic [23:0] data);
            t_result got;
            t_result want;
            got = data;
            if (reports_due.size() == 0) begin
                $error("line report 0x%06h arrived with none outstanding", data);
                mismatches++;
                return;
            end
            want = reports_due.pop_front();
            reports_checked++;
            if (got.nesting_depth !== want.nesting_depth) begin
                $error("nesting_depth: expected %0d, got %0d",
                       want.nesting_depth, got.nesting_depth);
                mismatches++;
            end
            if (got.inside_string !== want.inside_string) begin
                $error("inside_string: expected %0d, got %0d",
                       want.inside_string, got.inside_string);
                mismatches++;
            end
            if (got.quote_is_single !== want.quote_is_single) begin
                $error("quote_is_single: expected %0d, got %0d",
                       want.quote_is_single, got.quote_is_single);
                mismatches++;
            end
            if (got.inside_comment !== want.inside_comment) begin
                $error("inside_comment: expected %0d, got %0d",
                       want.inside_comment, got.inside_comment);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;  // [15:0] code_unit
    logic [1:0]  i_s_axis_tuser  = '0;  // [1:0] op
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;        // [15:0] depth, [16] string, [17] single, [18] comment

    line_state_tracker line_state = new();

    bit          idle_on     = 1'b0;
    int unsigned hold_asked  = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left   = 0;
    int unsigned cycle_count = 0;
    int unsigned beats_sent  = 0;

    bracket_depth_scanner_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[bracket_depth_scanner_core] ERROR");
            $finish;
        end
    end

    // Result side: random backpressure, plus a long hold-off on request so
    // the output stage fills and the block stalls its input.
    always @(posedge i_clk) begin
        if (hold_served != hold_asked) begin
            hold_served     <= hold_asked;
            hold_left       <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 12);
        end
    end

    // Sample result beats mid-cycle, where every signal has settled.
    always @(negedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            line_state.check_report(o_m_axis_tdata);
    end

    // Offer one beat and hold it until the block takes it.
    task automatic send_beat(input logic [1:0] op, input logic [15:0] unit);
        if (idle_on && $urandom_range(0, 99) < 12) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= unit;
        i_s_axis_tuser  <= op;
        @(negedge i_clk);
        while (!o_s_axis_tready)
            @(negedge i_clk);
        line_state.note_beat(op, unit);
        if (op != OP_UNUSED)
            beats_sent++;
        @(posedge i_clk);
    endtask

    // Send a line; an empty one becomes an empty-line beat. With
    // close_with_empty the last character stays held and an empty-line beat
    // ends the line instead.
    task automatic send_line(input logic [15:0] units[$], input bit close_with_empty);
        if (units.size() == 0) begin
            send_beat(OP_EMPTY, 16'($urandom));
            return;
        end
        foreach (units[i])
            send_beat((i == units.size() - 1 && !close_with_empty) ? OP_END : OP_MID,
                      units[i]);
        if (close_with_empty)
            send_beat(OP_EMPTY, 16'($urandom));
    endtask

    task automatic send_text(input string text);
        logic [15:0] units[$];
        for (int i = 0; i < text.len(); i++)
            units.push_back(16'(text[i]));
        send_line(units, 1'b0);
    endtask

    function automatic logic [15:0] pick_code_unit();
        case ($urandom_range(0, 19))
            0:       return 16'(CH_LBRACE);
            1:       return 16'(CH_RBRACE);
            2:       return 16'(CH_LBRACK);
            3:       return 16'(CH_RBRACK);
            4:       return 16'(CH_LPAREN);
            5:       return 16'(CH_RPAREN);
            6:       return 16'(CH_DQUOTE);
            7:       return 16'(CH_APOS);
            8, 9:    return 16'(CH_SLASH);
            10, 11:  return 16'(CH_STAR);
            12:      return 16'(CH_BSLASH);
            13:      return 16'($urandom_range(0, 16'hFFFF));
            // low byte looks like a bracket, high byte does not
            14:      return {8'($urandom_range(1, 255)), CH_LBRACE};
            default: return 16'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    // Build a line from tokens; comment markers and escaped quotes come as
    // pairs so the deeper lexical states are reached often.
    function automatic void random_line(ref logic [15:0] units[$]);
        int unsigned tokens;
        units.delete();
        tokens = $urandom_range(0, 8);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0: begin
                    units.push_back(16'(CH_SLASH));
                    units.push_back(16'(CH_STAR));
                end
                1: begin
                    units.push_back(16'(CH_STAR));
                    units.push_back(16'(CH_SLASH));
                end
                2: begin
                    units.push_back(16'(CH_SLASH));
                    units.push_back(16'(CH_SLASH));
                end
                3: begin
                    units.push_back(16'(CH_BSLASH));
                    units.push_back(16'($urandom_range(0, 1) ? CH_APOS : CH_DQUOTE));
                end
                default: units.push_back(pick_code_unit());
            endcase
        end
    endfunction

    initial begin
        logic [15:0] units[$];
        bit          hold_done;
        hold_done = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on <= 1'b1;

        // Directed lines: empty line first, then brackets with underflow,
        // strings with escapes, comments, pairs at line end, extremes.
        send_beat(OP_EMPTY, 16'hFFFF);
        send_text("{(");
        send_text("}])");
        send_text("\"\\\"'\"");
        send_text("'");
        send_text("\\'");
        send_text("x'/*");
        send_text("*/(/");
        send_text("//{");
        send_beat(OP_UNUSED, {8'h00, CH_LBRACE});
        send_beat(OP_MID, 16'hFFFF);
        send_beat(OP_MID, {8'h01, CH_LBRACE});
        send_beat(OP_END, 16'h0000);
        // a held character dropped by an empty-line beat
        send_beat(OP_MID, {8'h00, CH_LPAREN});
        send_beat(OP_EMPTY, 16'h0000);

        // Random lines: idle, then a long stretch without idling, then idle
        // again with one long hold-off on the result side.
        while (beats_sent < RANDOM_BEATS) begin
            idle_on <= !(beats_sent >= 180 && beats_sent < 300);
            if (!hold_done && beats_sent >= 320) begin
                hold_asked <= hold_asked + 1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 19) == 0)
                send_beat(OP_UNUSED, 16'($urandom));
            random_line(units);
            send_line(units, units.size() != 0 && $urandom_range(0, 24) == 0);
        end

        // Close whatever is open, then a last pair of bracket lines.
        if (line_state.comment_open)
            send_text("*/");
        if (line_state.string_open)
            send_text(line_state.quote_single ? "'" : "\"");
        send_text("[{");
        send_text(")]}");

        i_s_axis_tvalid <= 1'b0;
        idle_on         <= 1'b0;
        while (line_state.reports_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Scanned %0d character beats; %0d line reports checked, deepest %0d.",
                 beats_sent, line_state.reports_checked, line_state.deepest);
        $display("Covered strings, escapes, block and line comments, underflow, stalls.");
        if (line_state.mismatches == 0 && line_state.reports_due.size() == 0) begin
            $display("[bracket_depth_scanner_core] OK");
        end else begin
            $display("[bracket_depth_scanner_core] ERROR");
        end
        $finish;
    end

endmodule
